FILE: hdl/tcw_pkg.sv
package tcw_pkg;

  // Grid geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Internal widths follow from the geometry.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = $clog2(TAB_STOP);
  localparam int TL_W   = $clog2(TAB_STOP + 1);

  // Column phase within a tab stop of the last column.
  localparam int LAST_COL_PHASE = (COLUMNS - 1) % TAB_STOP;

  // Payload field widths of the transaction channels.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int FCOL_W   = 7;
  localparam int FROW_W   = 5;
  localparam int OFFSET_W = 11;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
  } cell_t;

  typedef struct packed {
    logic              we_char;
    logic              we_color;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } wr_req_t;

endpackage

FILE: hdl/tcw_cmd_if.sv
interface tcw_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::OP_W-1:0]    operation;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::FCOL_W-1:0]  read_col;
  logic [tcw_pkg::FROW_W-1:0]  read_row;

  modport source (output valid, operation, char_code, read_col, read_row, input ready);
  modport sink   (input valid, operation, char_code, read_col, read_row, output ready);
endinterface

FILE: hdl/tcw_rsp_if.sv
interface tcw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::FCOL_W-1:0]   cursor_col;
  logic [tcw_pkg::FROW_W-1:0]   cursor_row;
  logic [tcw_pkg::OFFSET_W-1:0] cursor_offset;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::COLOR_W-1:0]  cell_color;

  modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_char, cell_color,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cell_char, cell_color,
                  output ready);
endinterface

FILE: hdl/tcw_screen_store.sv
// Character and color planes of the screen, one write and one registered read a cycle.
module tcw_screen_store (
  input  logic                          clk_i,
  input  tcw_pkg::wr_req_t              wr_i,
  input  logic                          rd_en_i,
  input  logic [tcw_pkg::ADDR_W-1:0]    rd_addr_i,
  output tcw_pkg::cell_t                rd_data_o
);

  logic [tcw_pkg::CHAR_W-1:0]  char_mem  [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::COLOR_W-1:0] color_mem [tcw_pkg::CELL_COUNT];
  tcw_pkg::cell_t              rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_char) begin
      char_mem[wr_i.addr] <= wr_i.data.ch;
    end
    if (wr_i.we_color) begin
      color_mem[wr_i.addr] <= wr_i.data.color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q.ch    <= char_mem[rd_addr_i];
      rd_data_q.color <= color_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/text_console_writer.sv
// Character-cell text console with an 80 by 25 grid of cells, each holding a character and a
// color, and a cursor. Every command transaction produces exactly one response transaction
// that carries the cursor after the command and, for a cell read, the cell's character and
// color (zero otherwise). Commands are handled one at a time by a sequencer around the cell
// memory, which has one write port and one registered read port; that port sets the timing.
// A tab writes its spaces one after another, up to the next tab stop. Any command that runs
// past the last row scrolls the grid, which copies every cell one row up and blanks the last
// row. Clear screen writes every cell. After reset a clearing pass fills the grid with blank
// cells of color 7 before the first command is accepted; writes to the blank color register
// are taken at any time. A finished response waits in its own register, so the next command
// is accepted while it is pending.
module text_console_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata_i,
  tcw_cmd_if.sink                       cmd_i,
  tcw_rsp_if.source                     rsp_o
);

  // Sequencer states.
  localparam logic [3:0] S_INIT        = 4'd0;
  localparam logic [3:0] S_IDLE        = 4'd1;
  localparam logic [3:0] S_PUT         = 4'd2;
  localparam logic [3:0] S_BACKSPACE   = 4'd3;
  localparam logic [3:0] S_READ        = 4'd4;
  localparam logic [3:0] S_CLEAR       = 4'd5;
  localparam logic [3:0] S_SCROLL_COPY = 4'd6;
  localparam logic [3:0] S_SCROLL_FILL = 4'd7;
  localparam logic [3:0] S_DONE        = 4'd8;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ADDR   = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ROW_AD =
      tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_COPY   =
      tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL    = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW    = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::PH_W-1:0]   LAST_PHASE  = tcw_pkg::PH_W'(tcw_pkg::TAB_STOP - 1);

  logic [3:0]                      state_q, state_d;
  logic [tcw_pkg::ADDR_W-1:0]      sweep_q, sweep_d;
  logic [tcw_pkg::COL_W-1:0]       col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0]       row_q, row_d;
  // Cursor column modulo the tab stop, kept alongside the column.
  logic [tcw_pkg::PH_W-1:0]        phase_q, phase_d;
  // Spaces still to write for the current put; nonzero after a scroll resumes the put.
  logic [tcw_pkg::TL_W-1:0]        tab_left_q, tab_left_d;
  logic [tcw_pkg::CHAR_W-1:0]      put_code_q, put_code_d;
  logic [tcw_pkg::CHAR_W-1:0]      cell_char_q, cell_char_d;
  logic [tcw_pkg::COLOR_W-1:0]     cell_color_q, cell_color_d;
  logic                            wr_pend_q, wr_pend_d;
  logic [tcw_pkg::ADDR_W-1:0]      copy_addr_q, copy_addr_d;
  logic [tcw_pkg::COLOR_W-1:0]     blank_color_q;

  logic                            rsp_valid_q, rsp_valid_d;
  logic                            rsp_load;
  logic [tcw_pkg::FCOL_W-1:0]      rsp_col_q;
  logic [tcw_pkg::FROW_W-1:0]      rsp_row_q;
  logic [tcw_pkg::OFFSET_W-1:0]    rsp_offset_q;
  logic [tcw_pkg::CHAR_W-1:0]      rsp_char_q;
  logic [tcw_pkg::COLOR_W-1:0]     rsp_color_q;

  logic                            cmd_accept;
  logic [tcw_pkg::ADDR_W-1:0]      cursor_addr;
  logic [tcw_pkg::ADDR_W-1:0]      read_addr;
  logic                            read_in_grid;
  logic [tcw_pkg::COLOR_W-1:0]     fill_color;
  logic [3:0]                      after_scroll;

  tcw_pkg::wr_req_t                wr_req;
  logic                            rd_en;
  logic [tcw_pkg::ADDR_W-1:0]      rd_addr;
  tcw_pkg::cell_t                  rd_data;

  tcw_screen_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cmd_accept   = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready  = (state_q == S_IDLE);
  assign cursor_addr  = tcw_pkg::ADDR_W'(32'(row_q) * tcw_pkg::COLUMNS)
                      + tcw_pkg::ADDR_W'(col_q);
  assign read_in_grid = (32'(cmd_i.read_col) < tcw_pkg::COLUMNS)
                     && (32'(cmd_i.read_row) < tcw_pkg::ROWS);
  assign read_addr    = tcw_pkg::ADDR_W'(32'(cmd_i.read_row) * tcw_pkg::COLUMNS
                                         + 32'(cmd_i.read_col));
  // The reset pass always blanks with the reset color; later fills use the register.
  assign fill_color   = (state_q == S_INIT) ? tcw_pkg::RESET_COLOR : blank_color_q;
  // A scroll in the middle of a tab resumes the remaining spaces.
  assign after_scroll = (tab_left_q == '0) ? S_DONE : S_PUT;

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    col_d        = col_q;
    row_d        = row_q;
    phase_d      = phase_q;
    tab_left_d   = tab_left_q;
    put_code_d   = put_code_q;
    cell_char_d  = cell_char_q;
    cell_color_d = cell_color_q;
    wr_pend_d    = 1'b0;
    copy_addr_d  = copy_addr_q;
    rsp_load     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = read_addr;
    wr_req       = '0;

    // A copied cell goes out in the cycle after its read; this takes the write port.
    if (wr_pend_q) begin
      wr_req.we_char  = 1'b1;
      wr_req.we_color = 1'b1;
      wr_req.addr     = copy_addr_q;
      wr_req.data     = rd_data;
    end

    case (state_q)
      S_INIT, S_CLEAR: begin
        wr_req.we_char    = 1'b1;
        wr_req.we_color   = 1'b1;
        wr_req.addr       = sweep_q;
        wr_req.data.ch    = '0;
        wr_req.data.color = fill_color;
        if (sweep_q == LAST_ADDR) begin
          sweep_d = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (cmd_accept) begin
          cell_char_d  = '0;
          cell_color_d = '0;
          tab_left_d   = '0;
          state_d      = S_DONE;
          case (cmd_i.operation)
            tcw_pkg::OP_PUT: begin
              case (cmd_i.char_code)
                tcw_pkg::CODE_NEWLINE: begin
                  col_d   = '0;
                  phase_d = '0;
                  if (row_q == LAST_ROW) begin
                    sweep_d = '0;
                    state_d = S_SCROLL_COPY;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end
                tcw_pkg::CODE_RETURN: begin
                  col_d   = '0;
                  phase_d = '0;
                end
                tcw_pkg::CODE_TAB: begin
                  put_code_d = tcw_pkg::CODE_SPACE;
                  tab_left_d = tcw_pkg::TL_W'(tcw_pkg::TAB_STOP) - tcw_pkg::TL_W'(phase_q);
                  state_d    = S_PUT;
                end
                tcw_pkg::CODE_BACKSPACE: begin
                  if (col_q != '0) begin
                    col_d   = col_q - 1'b1;
                    phase_d = (phase_q == '0) ? LAST_PHASE : phase_q - 1'b1;
                  end else if (row_q != '0) begin
                    row_d   = row_q - 1'b1;
                    col_d   = LAST_COL;
                    phase_d = tcw_pkg::PH_W'(tcw_pkg::LAST_COL_PHASE);
                  end
                  state_d = S_BACKSPACE;
                end
                default: begin
                  put_code_d = cmd_i.char_code;
                  tab_left_d = tcw_pkg::TL_W'(1);
                  state_d    = S_PUT;
                end
              endcase
            end
            tcw_pkg::OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              phase_d = '0;
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              if (read_in_grid) begin
                rd_en   = 1'b1;
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_PUT: begin
        wr_req.we_char = 1'b1;
        wr_req.addr    = cursor_addr;
        wr_req.data.ch = put_code_q;
        tab_left_d     = tab_left_q - 1'b1;
        state_d        = (tab_left_q == tcw_pkg::TL_W'(1)) ? S_DONE : S_PUT;
        if (col_q == LAST_COL) begin
          col_d   = '0;
          phase_d = '0;
          if (row_q == LAST_ROW) begin
            sweep_d = '0;
            state_d = S_SCROLL_COPY;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d   = col_q + 1'b1;
          phase_d = (phase_q == LAST_PHASE) ? '0 : phase_q + 1'b1;
        end
      end

      S_BACKSPACE: begin
        wr_req.we_char = 1'b1;
        wr_req.addr    = cursor_addr;
        wr_req.data.ch = tcw_pkg::CODE_SPACE;
        state_d        = S_DONE;
      end

      S_READ: begin
        cell_char_d  = rd_data.ch;
        cell_color_d = rd_data.color;
        state_d      = S_DONE;
      end

      S_SCROLL_COPY: begin
        // Read the cell one row below; it is written to this address next cycle.
        rd_en       = 1'b1;
        rd_addr     = sweep_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        wr_pend_d   = 1'b1;
        copy_addr_d = sweep_q;
        if (sweep_q == LAST_COPY) begin
          sweep_d = LAST_ROW_AD;
          state_d = S_SCROLL_FILL;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      S_SCROLL_FILL: begin
        // The first cycle here drains the last copied cell.
        if (!wr_pend_q) begin
          wr_req.we_char    = 1'b1;
          wr_req.we_color   = 1'b1;
          wr_req.addr       = sweep_q;
          wr_req.data.ch    = '0;
          wr_req.data.color = fill_color;
          if (sweep_q == LAST_ADDR) begin
            sweep_d = '0;
            state_d = after_scroll;
          end else begin
            sweep_d = sweep_q + 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      sweep_q       <= '0;
      col_q         <= '0;
      row_q         <= '0;
      phase_q       <= '0;
      tab_left_q    <= '0;
      wr_pend_q     <= 1'b0;
      rsp_valid_q   <= 1'b0;
      blank_color_q <= tcw_pkg::RESET_COLOR;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      col_q       <= col_d;
      row_q       <= row_d;
      phase_q     <= phase_d;
      tab_left_q  <= tab_left_d;
      wr_pend_q   <= wr_pend_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        blank_color_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    put_code_q   <= put_code_d;
    cell_char_q  <= cell_char_d;
    cell_color_q <= cell_color_d;
    copy_addr_q  <= copy_addr_d;
    if (rsp_load) begin
      rsp_col_q    <= tcw_pkg::FCOL_W'(col_q);
      rsp_row_q    <= tcw_pkg::FROW_W'(row_q);
      rsp_offset_q <= tcw_pkg::OFFSET_W'(cursor_addr);
      rsp_char_q   <= cell_char_q;
      rsp_color_q  <= cell_color_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.cursor_col    = rsp_col_q;
  assign rsp_o.cursor_row    = rsp_row_q;
  assign rsp_o.cursor_offset = rsp_offset_q;
  assign rsp_o.cell_char     = rsp_char_q;
  assign rsp_o.cell_color    = rsp_color_q;

endmodule

FILE: bench/text_console_writer_tb.sv
`timescale 1ns / 1ps

module text_console_writer_tb;

  // Operation code that the block leaves unused; it must change nothing.
  localparam logic [tcw_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  // Longest stretch without any transaction before the run is declared hung. The slowest
  // legal gap is a scroll or the clearing pass after reset, plus the receiver hold-off,
  // so this leaves a wide margin.
  localparam int STALL_LIMIT     = 20000;
  // Cycles to linger after the last response.
  localparam int DRAIN_CYCLES    = 50;
  localparam int HOLD_CYCLES     = 500;
  localparam int IDLE_PERCENT    = 14;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int PHASES          = 5;
  localparam int MAX_REPORTS     = 10;

  // One response transaction as the console reports it.
  typedef struct packed {
    logic [tcw_pkg::FCOL_W-1:0]   col;
    logic [tcw_pkg::FROW_W-1:0]   row;
    logic [tcw_pkg::OFFSET_W-1:0] offset;
    logic [tcw_pkg::CHAR_W-1:0]   ch;
    logic [tcw_pkg::COLOR_W-1:0]  color;
  } screen_view_t;

  // The scoreboard keeps its own copy of the character grid, the cursor and the blank
  // color, and turns every accepted command into the response it must produce.
  class console_scoreboard;
    tcw_pkg::cell_t              cells [tcw_pkg::CELL_COUNT];
    int unsigned                 cur_col;
    int unsigned                 cur_row;
    logic [tcw_pkg::COLOR_W-1:0] blank_color;
    screen_view_t                expected_q [$];
    int                          mismatches;

    function new();
      blank_color = tcw_pkg::RESET_COLOR;
      blank_grid();
      cur_col    = 0;
      cur_row    = 0;
      mismatches = 0;
    endfunction

    function void set_color(logic [tcw_pkg::COLOR_W-1:0] color);
      blank_color = color;
    endfunction

    function void blank_grid();
      foreach (cells[i]) begin
        cells[i].ch    = '0;
        cells[i].color = blank_color;
      end
    endfunction

    // Wrap past the last column, then scroll everything up one row when the cursor
    // falls off the bottom. The new bottom row takes the current blank color.
    function void settle_cursor();
      int i;
      if (cur_col >= tcw_pkg::COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= tcw_pkg::ROWS) begin
        for (i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
          cells[i] = cells[i + tcw_pkg::COLUMNS];
        for (i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++) begin
          cells[i].ch    = '0;
          cells[i].color = blank_color;
        end
        cur_row = tcw_pkg::ROWS - 1;
      end
    endfunction

    // A plain character replaces only the character byte; the cell keeps its color.
    function void put_plain(logic [tcw_pkg::CHAR_W-1:0] code);
      cells[cur_row * tcw_pkg::COLUMNS + cur_col].ch = code;
      cur_col++;
      settle_cursor();
    endfunction

    function void note_command(logic [tcw_pkg::OP_W-1:0] op, logic [tcw_pkg::CHAR_W-1:0] code,
                               logic [tcw_pkg::FCOL_W-1:0] rd_col,
                               logic [tcw_pkg::FROW_W-1:0] rd_row);
      screen_view_t view;
      int unsigned  spaces;
      view = '0;
      case (op)
        tcw_pkg::OP_PUT: begin
          case (code)
            tcw_pkg::CODE_NEWLINE: begin
              cur_col = 0;
              cur_row++;
              settle_cursor();
            end
            tcw_pkg::CODE_RETURN: cur_col = 0;
            tcw_pkg::CODE_TAB: begin
              // Always at least one space, each one subject to wrap and scroll.
              spaces = tcw_pkg::TAB_STOP - (cur_col % tcw_pkg::TAB_STOP);
              repeat (spaces) put_plain(tcw_pkg::CODE_SPACE);
            end
            tcw_pkg::CODE_BACKSPACE: begin
              if (cur_col > 0) begin
                cur_col--;
              end else if (cur_row > 0) begin
                cur_row--;
                cur_col = tcw_pkg::COLUMNS - 1;
              end
              cells[cur_row * tcw_pkg::COLUMNS + cur_col].ch = tcw_pkg::CODE_SPACE;
            end
            default: put_plain(code);
          endcase
        end
        tcw_pkg::OP_CLEAR: begin
          blank_grid();
          cur_col = 0;
          cur_row = 0;
        end
        tcw_pkg::OP_READ: begin
          // Reads outside the grid return zero for both cell fields.
          if (rd_col < tcw_pkg::COLUMNS && rd_row < tcw_pkg::ROWS) begin
            view.ch    = cells[rd_row * tcw_pkg::COLUMNS + rd_col].ch;
            view.color = cells[rd_row * tcw_pkg::COLUMNS + rd_col].color;
          end
        end
        default: ;
      endcase
      view.col    = tcw_pkg::FCOL_W'(cur_col);
      view.row    = tcw_pkg::FROW_W'(cur_row);
      view.offset = tcw_pkg::OFFSET_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
      expected_q.push_back(view);
    endfunction

    function void check_response(screen_view_t got);
      screen_view_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response transaction with nothing outstanding: col %0d row %0d",
                   $time, got.col, got.row);
        return;
      end
      want = expected_q.pop_front();
      if (got.col !== want.col || got.row !== want.row || got.offset !== want.offset ||
          got.ch !== want.ch || got.color !== want.color) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: mismatch: want col %0d row %0d offset %0d char %h color %h, ",
                    "got col %0d row %0d offset %0d char %h color %h"},
                   $time, want.col, want.row, want.offset, want.ch, want.color,
                   got.col, got.row, got.offset, got.ch, got.color);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [tcw_pkg::COLOR_W-1:0] cfg_wdata;

  tcw_cmd_if cmd_ch ();
  tcw_rsp_if rsp_ch ();

  console_scoreboard sb;
  int commands_sent  = 0;
  int responses_seen = 0;
  int quiet_cycles   = 0;

  text_console_writer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_ch),
    .rsp_o       (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one command transaction and return once it has been accepted. Valid stays high
  // across back-to-back commands; it only drops for a random idle gap or a drain. The
  // sender never idles while commands 300 to 449 go out.
  task automatic send_command(input logic [tcw_pkg::OP_W-1:0] op,
                              input logic [tcw_pkg::CHAR_W-1:0] code,
                              input logic [tcw_pkg::FCOL_W-1:0] rd_col,
                              input logic [tcw_pkg::FROW_W-1:0] rd_row);
    bit calm;
    calm = (commands_sent >= 300) && (commands_sent < 450);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.char_code <= code;
    cmd_ch.read_col  <= rd_col;
    cmd_ch.read_row  <= rd_row;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(op, code, rd_col, rd_row);
    commands_sent++;
  endtask

  // Mostly printable traffic with control codes and reads mixed in. Clears are kept rare
  // so the cursor reaches the bottom row and the grid scrolls often; the fields a command
  // does not use carry random noise.
  task automatic send_random_command(input int newline_pct);
    int                         pick;
    int                         nl;
    logic [tcw_pkg::CHAR_W-1:0] code;
    logic [tcw_pkg::FCOL_W-1:0] rd_col;
    logic [tcw_pkg::FROW_W-1:0] rd_row;
    pick   = $urandom_range(0, 999);
    nl     = newline_pct * 10;
    code   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    rd_col = tcw_pkg::FCOL_W'($urandom_range(0, 127));
    rd_row = tcw_pkg::FROW_W'($urandom_range(0, 31));
    if (pick < nl)
      send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_NEWLINE, rd_col, rd_row);
    else if (pick < nl + 30)
      send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_RETURN, rd_col, rd_row);
    else if (pick < nl + 80)
      send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_TAB, rd_col, rd_row);
    else if (pick < nl + 130)
      send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, rd_col, rd_row);
    else if (pick < nl + 260)
      send_command(tcw_pkg::OP_READ, code,
                   tcw_pkg::FCOL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1)),
                   tcw_pkg::FROW_W'($urandom_range(0, tcw_pkg::ROWS - 1)));
    else if (pick < nl + 290)
      send_command(tcw_pkg::OP_READ, code, rd_col, rd_row);
    else if (pick < nl + 294)
      send_command(tcw_pkg::OP_CLEAR, code, rd_col, rd_row);
    else if (pick < nl + 300)
      send_command(OP_SPARE, code, rd_col, rd_row);
    else
      send_command(tcw_pkg::OP_PUT, code, rd_col, rd_row);
  endtask

  // Corner cases run with the reset color: reads of the corners and outside the grid, the
  // extreme character codes, tabs from different columns, backspace across a row boundary
  // and at the top-left cell, wrap at the last column, the unused operation and clear.
  task automatic send_edge_cases();
    send_command(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_READ, 8'hFF, 7'd79, 5'd24);
    send_command(tcw_pkg::OP_READ, 8'h5A, 7'd127, 5'd31);
    send_command(tcw_pkg::OP_PUT, 8'd65, 7'd127, 5'd31);
    send_command(tcw_pkg::OP_PUT, 8'h00, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, 8'hFF, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_TAB, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_TAB, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_RETURN, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_NEWLINE, 7'd0, 5'd0);
    // Backspace at column zero climbs to the last column of the row above.
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, 8'd66, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, 7'd0, 5'd0);
    // A tab from the last column writes one space and wraps.
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_TAB, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 7'd79, 5'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0);
    send_command(OP_SPARE, 8'hA5, 7'd42, 5'd17);
    send_command(tcw_pkg::OP_CLEAR, 8'h00, 7'd0, 5'd0);
    // At the top-left cell backspace stays put and still blanks the cell.
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, tcw_pkg::CODE_NEWLINE, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_PUT, 8'h7F, 7'd0, 5'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd1);
  endtask

  // Stop offering commands and wait until every outstanding response has come back.
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The color register is only touched while the console is idle.
  task automatic write_color(input logic [tcw_pkg::COLOR_W-1:0] color);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_color(color);
  endtask

  // Main sequence: reset, corner cases, then random phases, each under its own blank color.
  initial begin
    logic [tcw_pkg::COLOR_W-1:0] phase_colors [PHASES];
    int                          p;
    int                          k;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = '0;
    cmd_ch.char_code = '0;
    cmd_ch.read_col  = '0;
    cmd_ch.read_row  = '0;
    sb               = new();
    phase_colors[0]  = 8'hFF;
    phase_colors[1]  = 8'h00;
    phase_colors[2]  = tcw_pkg::COLOR_W'($urandom_range(1, 254));
    phase_colors[3]  = tcw_pkg::RESET_COLOR;
    phase_colors[4]  = tcw_pkg::COLOR_W'($urandom_range(1, 254));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_edge_cases();
    for (p = 0; p < PHASES; p++) begin
      wait_for_drain();
      write_color(phase_colors[p]);
      // Odd phases are heavy on newlines so the bottom row and scrolling get a workout.
      for (k = 0; k < ITEMS_PER_PHASE; k++) send_random_command((p % 2 == 1) ? 20 : 6);
    end
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.mismatches++;
    if (sb.mismatches == 0)
      $display("[text_console_writer] OK");
    else
      $display("[text_console_writer] ERROR");
    $finish;
  end

  // Response side: check every accepted response transaction and toggle ready at random.
  // Once, after 600 responses, ready is held low for a long stretch so the console fills
  // up and stalls its command side. Responses 300 to 449 are taken without stalls.
  initial begin
    int          hold_left;
    bit          held_once;
    screen_view_t got;
    hold_left    = 0;
    held_once    = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.col    = rsp_ch.cursor_col;
        got.row    = rsp_ch.cursor_row;
        got.offset = rsp_ch.cursor_offset;
        got.ch     = rsp_ch.cell_char;
        got.color  = rsp_ch.cell_color;
        sb.check_response(got);
        responses_seen++;
      end
      if (!held_once && responses_seen == 600) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (responses_seen >= 300 && responses_seen < 450) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: any accepted transaction on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[text_console_writer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
hdl/tcw_pkg.sv
hdl/tcw_cmd_if.sv
hdl/tcw_rsp_if.sv
hdl/tcw_screen_store.sv
hdl/text_console_writer.sv
bench/text_console_writer_tb.sv
